// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the projection RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, register codes and reset values of the projection unit.
// ----------------------------------------------------------------------------
package wsp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int SIZE_W        = 14;
    localparam int PIX_W         = 16;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 64;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_LO = 4'd0,
        REG_ROW0_HI = 4'd1,
        REG_ROW1_LO = 4'd2,
        REG_ROW1_HI = 4'd3,
        REG_ROW3_LO = 4'd4,
        REG_ROW3_HI = 4'd5,
        REG_WIDTH   = 4'd6,
        REG_HEIGHT  = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic adv;
    } pipe_ctl_t;
endpackage

// ===== rtl/core/wsp_point_if.sv =====
// ----------------------------------------------------------------------------
// wsp_point_if
// Input channel carrying one world point per item.
// ----------------------------------------------------------------------------
interface wsp_point_if;
    import wsp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== rtl/core/wsp_pixel_if.sv =====
// ----------------------------------------------------------------------------
// wsp_pixel_if
// Output channel carrying one screen position per item.
// ----------------------------------------------------------------------------
interface wsp_pixel_if;
    import wsp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    visible;
    logic signed [PIX_W-1:0] screen_x;
    logic signed [PIX_W-1:0] screen_y;

    modport source (output valid, visible, screen_x, screen_y, input ready);
    modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

// ===== rtl/core/wsp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wsp_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface wsp_cfg_if;
    import wsp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wsp_dot.sv =====
// ----------------------------------------------------------------------------
// wsp_dot
// Three-stage row dot product: products, partial sums, clip value.
// ----------------------------------------------------------------------------
module wsp_dot #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF,
    parameter int CLIP_W    = 2 * wsp_pkg::COORD_W - FRAC_BITS + 3
) (
    input  logic                              clk,
    input  wsp_pkg::pipe_ctl_t                ctl,
    input  logic signed [wsp_pkg::COORD_W-1:0] pos_x,
    input  logic signed [wsp_pkg::COORD_W-1:0] pos_y,
    input  logic signed [wsp_pkg::COORD_W-1:0] pos_z,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]    row_lo,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]    row_hi,
    output logic signed [CLIP_W-1:0]          clip
);
    import wsp_pkg::*;

    localparam int PROD_W = 2 * COORD_W;

    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [COORD_W-1:0] ofs_reg;
    logic signed [CLIP_W-1:0]  sh [3];
    logic signed [CLIP_W-1:0]  sum_a_reg;
    logic signed [CLIP_W-1:0]  sum_b_reg;
    logic signed [CLIP_W-1:0]  clip_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            prod_reg[0] <= pos_x * $signed(row_lo[31:0]);
            prod_reg[1] <= pos_y * $signed(row_lo[63:32]);
            prod_reg[2] <= pos_z * $signed(row_hi[31:0]);
            ofs_reg     <= $signed(row_hi[63:32]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh[i] = CLIP_W'(prod_reg[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            sum_a_reg <= sh[0] + sh[1];
            sum_b_reg <= sh[2] + CLIP_W'(ofs_reg);
            clip_reg  <= sum_a_reg + sum_b_reg;
        end
    end

    assign clip = clip_reg;
endmodule

// ===== rtl/core/wsp_map.sv =====
// ----------------------------------------------------------------------------
// wsp_map
// Pixel mapping: size scaling, then a restoring divide one bit per stage,
// with saturation to the pixel range.
// ----------------------------------------------------------------------------
module wsp_map #(
    parameter int A_W = 2 * wsp_pkg::COORD_W - wsp_pkg::FRAC_BITS_DEF + 4
) (
    input  logic                              clk,
    input  wsp_pkg::pipe_ctl_t                ctl,
    input  logic signed [A_W-1:0]             num,
    input  logic signed [A_W-1:0]             w,
    input  logic [wsp_pkg::SIZE_W-1:0]        size,
    output logic signed [wsp_pkg::PIX_W-1:0]  pix
);
    import wsp_pkg::*;

    localparam int LO_W  = A_W / 2;
    localparam int HI_W  = A_W - LO_W;
    localparam int N_W   = A_W + SIZE_W + 1;
    localparam int R_W   = N_W + 1;
    localparam int QB    = PIX_W - 1;
    localparam int STG   = PIX_W;

    logic [LO_W+SIZE_W-1:0]          plo_reg;
    logic signed [HI_W+SIZE_W:0]     phi_reg;
    logic signed [A_W-1:0]           w5_reg;
    logic signed [A_W-1:0]           w6_reg;
    logic [N_W-1:0]                  n_reg;
    logic [R_W-1:0]                  rem_reg [STG+1];
    logic [A_W-1:0]                  dd_reg  [STG+1];
    logic [QB-1:0]                   q_reg   [STG+1];
    logic [STG:0]                    neg_reg;
    logic [STG:0]                    sat_reg;
    logic signed [PIX_W-1:0]         pix_reg;
    logic [PIX_W-1:0]                mag;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            plo_reg <= size * num[LO_W-1:0];
            phi_reg <= $signed({1'b0, size}) * $signed(num[A_W-1:LO_W]);
            w5_reg  <= w;
            n_reg   <= N_W'((N_W'(phi_reg) <<< LO_W) + N_W'(plo_reg) + N_W'(w5_reg));
            w6_reg  <= w5_reg;
            neg_reg[0] <= n_reg[N_W-1];
            rem_reg[0] <= R_W'(n_reg[N_W-1] ? ~n_reg : n_reg) & {1'b0, {(R_W-1){1'b1}} >> 1};
            dd_reg[0]  <= A_W'(w6_reg <<< 1);
            q_reg[0]   <= '0;
            sat_reg[0] <= 1'b0;
        end
    end

    for (genvar j = 0; j < STG; j++)
    begin : g_div
        localparam int K = STG - 1 - j;
        logic [R_W-1:0] shd;
        logic           ge;
        assign shd = R_W'(dd_reg[j]) << K;
        assign ge  = rem_reg[j] >= shd;

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                dd_reg[j+1]  <= dd_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                if (j == 0)
                begin
                    rem_reg[j+1] <= rem_reg[j];
                    q_reg[j+1]   <= q_reg[j];
                    sat_reg[j+1] <= ge;
                end
                else
                begin
                    sat_reg[j+1] <= sat_reg[j];
                    if (ge && !sat_reg[j])
                    begin
                        rem_reg[j+1] <= rem_reg[j] - shd;
                        q_reg[j+1]   <= q_reg[j] | (QB'(1) << K);
                    end
                    else
                    begin
                        rem_reg[j+1] <= rem_reg[j];
                        q_reg[j+1]   <= q_reg[j];
                    end
                end
            end
        end
    end

    assign mag = sat_reg[STG] ? {1'b0, {QB{1'b1}}} : {1'b0, q_reg[STG]};

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            pix_reg <= $signed(neg_reg[STG] ? ~mag : mag);
        end
    end

    assign pix = pix_reg;
endmodule

// ===== rtl/core/world_to_screen_projection_unit.sv =====
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects world points to screen pixels through a programmable view matrix.
// ----------------------------------------------------------------------------
// Usage:
//   pt  : input items, one world point (pos_x, pos_y, pos_z), signed fixed
//         point. Taken when valid and ready are high.
//   px  : result items, visible flag and screen_x / screen_y pixels.
//   cfg : register writes (index, data), always ready; write only while
//         the pipeline is empty.
// Throughput is one item per cycle while px is not stalled. An item passes
// the three-stage dot product, one combine stage, three scaling stages and
// the sixteen-stage restoring divider, whose first stage checks saturation
// and whose later stages each yield one pixel bit, plus the output register.
// Reset empties the pipeline and returns the matrix to zero and the screen
// size to 1920 x 1080. When px is stalled the whole pipeline holds, pt.ready
// drops, and no item is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module world_to_screen_projection_unit #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    wsp_point_if.sink   pt,
    wsp_pixel_if.source px,
    wsp_cfg_if.sink     cfg
);
    import wsp_pkg::*;

    localparam int CLIP_W = 2 * COORD_W - FRAC_BITS + 3;
    localparam int A_W    = CLIP_W + 1;
    localparam int MAP_L  = 3 + PIX_W + 1;
    localparam int LAT    = 3 + 1 + MAP_L;
    localparam logic signed [CLIP_W-1:0] W_MIN =
        CLIP_W'(((64'sd1 << FRAC_BITS) + 64'sd50) / 64'sd100);

    logic [CFG_DATA_W-1:0] row_reg [6];
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [LAT-1:0]        vld_reg;
    logic [MAP_L:0]        vis_reg;
    pipe_ctl_t             ctl;

    logic signed [CLIP_W-1:0] cw;
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [A_W-1:0]    ax_reg;
    logic signed [A_W-1:0]    ay_reg;
    logic signed [A_W-1:0]    w_reg;
    logic signed [PIX_W-1:0]  pix_x;
    logic signed [PIX_W-1:0]  pix_y;

    assign ctl.adv   = !vld_reg[LAT-1] || px.ready;
    assign pt.ready  = ctl.adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                row_reg[i] <= '0;
            end
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_ROW0_LO: row_reg[0] <= cfg.data;
                REG_ROW0_HI: row_reg[1] <= cfg.data;
                REG_ROW1_LO: row_reg[2] <= cfg.data;
                REG_ROW1_HI: row_reg[3] <= cfg.data;
                REG_ROW3_LO: row_reg[4] <= cfg.data;
                REG_ROW3_HI: row_reg[5] <= cfg.data;
                REG_WIDTH:   width_reg  <= cfg.data[SIZE_W-1:0];
                REG_HEIGHT:  height_reg <= cfg.data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pt.valid};
        end
    end

    wsp_dot #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_dot_x (
        .clk(clk), .ctl(ctl), .pos_x(pt.pos_x), .pos_y(pt.pos_y), .pos_z(pt.pos_z),
        .row_lo(row_reg[0]), .row_hi(row_reg[1]), .clip(cx)
    );
    wsp_dot #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_dot_y (
        .clk(clk), .ctl(ctl), .pos_x(pt.pos_x), .pos_y(pt.pos_y), .pos_z(pt.pos_z),
        .row_lo(row_reg[2]), .row_hi(row_reg[3]), .clip(cy)
    );
    wsp_dot #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_dot_w (
        .clk(clk), .ctl(ctl), .pos_x(pt.pos_x), .pos_y(pt.pos_y), .pos_z(pt.pos_z),
        .row_lo(row_reg[4]), .row_hi(row_reg[5]), .clip(cw)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            ax_reg     <= A_W'(cw) + A_W'(cx);
            ay_reg     <= A_W'(cw) - A_W'(cy);
            w_reg      <= A_W'(cw);
            vis_reg[0] <= cw >= W_MIN;
            vis_reg[MAP_L:1] <= vis_reg[MAP_L-1:0];
        end
    end

    wsp_map #(.A_W(A_W)) u_map_x (
        .clk(clk), .ctl(ctl), .num(ax_reg), .w(w_reg), .size(width_reg), .pix(pix_x)
    );
    wsp_map #(.A_W(A_W)) u_map_y (
        .clk(clk), .ctl(ctl), .num(ay_reg), .w(w_reg), .size(height_reg), .pix(pix_y)
    );

    assign px.valid    = vld_reg[LAT-1];
    assign px.visible  = vis_reg[MAP_L];
    assign px.screen_x = vis_reg[MAP_L] ? pix_x : '0;
    assign px.screen_y = vis_reg[MAP_L] ? pix_y : '0;

    `ASSERT_CLK(a_hidden_zero, clk, rst_n,
        px.valid && !px.visible |-> px.screen_x == 0 && px.screen_y == 0,
        "hidden item with nonzero coordinates")
    `ASSERT_CLK(a_accept_enters, clk, rst_n,
        pt.valid && pt.ready |=> vld_reg[0], "accepted item not in pipeline")
    `ASSERT_CLK(a_stall_holds, clk, rst_n,
        !ctl.adv |=> $stable(vld_reg), "pipeline moved during stall")
endmodule
